/* src/sfr_pkg.sv */
// shared constants, codes and types of the serial frame receiver
package sfr_pkg;

  // frame layout
  localparam int HEADER_BYTES  = 10;
  localparam int LENGTH_OFFSET = 1;
  localparam int MAX_PAYLOAD   = 256;
  localparam int BUF_BYTES     = HEADER_BYTES + MAX_PAYLOAD;
  localparam int STORE_DEPTH   = 2 * BUF_BYTES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int OFS_W         = $clog2(BUF_BYTES + 1);

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // register reset values
  localparam logic [7:0] START_BYTE_RST    = 8'd2;
  localparam logic [8:0] PAYLOAD_LIMIT_RST = 9'd256;
  localparam logic [8:0] MAX_PAYLOAD_L     = 9'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_ENDPOINT    = 4'd1,
    ST_HEADER      = 4'd2,
    ST_PAYLOAD     = 4'd3,
    ST_CHECK       = 4'd4,
    ST_READY       = 4'd5,
    ST_ERR_START   = 4'd6,
    ST_ERR_LENGTH  = 4'd7,
    ST_ERR_CHECK   = 4'd8,
    ST_ERR_OVERRUN = 4'd9
  } sfr_status_e;

  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_QUERY   = 2'd1,
    OP_READ    = 2'd2,
    OP_RELEASE = 2'd3
  } sfr_op_e;

  typedef enum logic {
    CFG_START_BYTE    = 1'b0,
    CFG_PAYLOAD_LIMIT = 1'b1
  } sfr_cfg_e;

  // result fields computed by the front, before the store read returns
  typedef struct packed {
    sfr_status_e rx_status;
    sfr_status_e held_status;
    logic [7:0]  endpoint;
    logic [8:0]  payload_length;
    logic        error_latched;
    logic        wake;
    logic        read_hit;
  } sfr_res_t;

  // complete result item
  typedef struct packed {
    sfr_status_e rx_status;
    sfr_status_e held_status;
    logic [7:0]  endpoint;
    logic [8:0]  payload_length;
    logic [7:0]  read_byte;
    logic        error_latched;
    logic        wake;
  } sfr_out_t;

  // frame store access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } sfr_mem_req_t;

endpackage

/* src/serial_frame_receiver.sv */
// serial frame receiver: two ping-pong frame buffers with xor-checked deframing
// an accepted item passes the staging register and the result queue before its result is offered
// throughput: one item per cycle while in_stall_o is low, one parser state update per item
// in_stall_o rises once queued plus staged results reach the four-entry queue depth
// reset: asynchronous, clears buffer states, counters and flags, start byte 2, limit 256
// the frame store is not cleared by reset; only bytes of a ready frame are read
module serial_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic [8:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] rx_status_o,
  output logic [3:0] held_status_o,
  output logic [7:0] endpoint_o,
  output logic [8:0] payload_length_o,
  output logic [7:0] read_byte_o,
  output logic       error_latched_o,
  output logic       wake_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  logic                  ready;
  logic                  res_valid;
  sfr_pkg::sfr_res_t     res;
  sfr_pkg::sfr_mem_req_t mem_req;
  sfr_pkg::sfr_out_t     out;
  logic [7:0]            rdata;

  assign in_stall_o = !ready;

  // parser front end
  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .ready_i      (ready),
    .operation_i  (operation_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_o        (mem_req)
  );

  // frame store for both buffers
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (sfr_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // result queue back end
  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .rdata_i     (rdata),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign rx_status_o      = out.rx_status;
  assign held_status_o    = out.held_status;
  assign endpoint_o       = out.endpoint;
  assign payload_length_o = out.payload_length;
  assign read_byte_o      = out.read_byte;
  assign error_latched_o  = out.error_latched;
  assign wake_o           = out.wake;

endmodule

/* src/sfr_ram.sv */
// generic single write, single read ram with registered read data
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/sfr_front.sv */
// front end: accepts items, runs the frame parser and buffer bookkeeping
module sfr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  ready_i,
  input  logic [1:0]            operation_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [8:0]            read_index_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [8:0]            cfg_data_i,
  output logic                  res_valid_o,
  output sfr_pkg::sfr_res_t     res_o,
  output sfr_pkg::sfr_mem_req_t mem_o
);

  localparam int OW = sfr_pkg::OFS_W;
  localparam int AW = sfr_pkg::ADDR_W;

  sfr_pkg::sfr_status_e status_q [2];
  sfr_pkg::sfr_status_e status_d [2];
  logic [7:0]  ep_q [2];
  logic [7:0]  ep_d [2];
  logic [8:0]  len_q [2];
  logic [8:0]  len_d [2];
  logic [OW-1:0] exp_q, exp_d;
  logic [OW-1:0] ofs_q, ofs_d;
  logic [7:0]  xor_q, xor_d;
  logic        fill_q, fill_d;
  logic        drain_q, drain_d;
  logic        err_q, err_d;
  logic [8:0]  lenlo_q, lenlo_d;
  logic        lenhi_q, lenhi_d;
  logic [7:0]  start_q, start_d;
  logic [8:0]  limit_q, limit_d;

  logic          accept;
  logic          wake;
  logic          b;
  logic [7:0]    v;
  logic [7:0]    xor_n;
  logic [OW-1:0] ofs_inc;
  logic [8:0]    lo_n;
  logic          hi_n;
  logic [1:0]    k;
  logic          in_window;
  logic [8:0]    limit;
  logic          store_en;
  logic          hit;
  sfr_pkg::sfr_op_e op;

  assign accept  = in_valid_i && ready_i;
  assign op      = sfr_pkg::sfr_op_e'(operation_i);
  assign b       = fill_q;
  assign v       = rx_byte_i;
  assign xor_n   = xor_q ^ v;
  assign ofs_inc = ofs_q + OW'(1);
  assign limit   = (limit_q < sfr_pkg::MAX_PAYLOAD_L) ? limit_q : sfr_pkg::MAX_PAYLOAD_L;

  // length field assembly from the header byte now arriving
  assign in_window = (ofs_q >= OW'(sfr_pkg::LENGTH_OFFSET)) &&
                     (ofs_q < OW'(sfr_pkg::LENGTH_OFFSET + 4));
  assign k = 2'(ofs_q - OW'(sfr_pkg::LENGTH_OFFSET));

  always_comb begin
    lo_n = lenlo_q;
    hi_n = lenhi_q;
    if (in_window) begin
      case (k)
        2'd0: lo_n[7:0] = v;
        2'd1: begin
          lo_n[8] = v[0];
          hi_n    = lenhi_q | (|v[7:1]);
        end
        default: hi_n = lenhi_q | (|v);
      endcase
    end
  end

  // parser and release next state
  always_comb begin
    status_d = status_q;
    ep_d     = ep_q;
    len_d    = len_q;
    exp_d    = exp_q;
    ofs_d    = ofs_q;
    xor_d    = xor_q;
    fill_d   = fill_q;
    drain_d  = drain_q;
    err_d    = err_q;
    lenlo_d  = lenlo_q;
    lenhi_d  = lenhi_q;
    wake     = 1'b0;
    store_en = 1'b0;
    if (accept) begin
      case (op)
        sfr_pkg::OP_RECEIVE: begin
          if (!err_q) begin
            case (status_q[b])
              sfr_pkg::ST_IDLE: begin
                if (v != start_q) begin
                  status_d[b] = sfr_pkg::ST_ERR_START;
                  err_d       = 1'b1;
                  wake        = 1'b1;
                end else begin
                  ep_d[b]     = 8'd0;
                  len_d[b]    = 9'd0;
                  ofs_d       = '0;
                  xor_d       = 8'd0;
                  exp_d       = '0;
                  status_d[b] = sfr_pkg::ST_ENDPOINT;
                end
              end
              sfr_pkg::ST_ENDPOINT: begin
                ep_d[b]     = v;
                xor_d       = v;
                exp_d       = OW'(sfr_pkg::HEADER_BYTES);
                ofs_d       = '0;
                lenlo_d     = 9'd0;
                lenhi_d     = 1'b0;
                status_d[b] = sfr_pkg::ST_HEADER;
              end
              sfr_pkg::ST_HEADER: begin
                xor_d    = xor_n;
                store_en = 1'b1;
                ofs_d    = ofs_inc;
                lenlo_d  = lo_n;
                lenhi_d  = hi_n;
                if (ofs_inc >= OW'(sfr_pkg::HEADER_BYTES)) begin
                  if (hi_n || (lo_n > limit)) begin
                    status_d[b] = sfr_pkg::ST_ERR_LENGTH;
                    err_d       = 1'b1;
                    wake        = 1'b1;
                  end else begin
                    len_d[b] = lo_n;
                    if (lo_n != 9'd0) begin
                      exp_d       = OW'(sfr_pkg::HEADER_BYTES) + OW'(lo_n);
                      status_d[b] = sfr_pkg::ST_PAYLOAD;
                    end else begin
                      status_d[b] = sfr_pkg::ST_CHECK;
                    end
                  end
                end
              end
              sfr_pkg::ST_PAYLOAD: begin
                xor_d    = xor_n;
                store_en = 1'b1;
                ofs_d    = ofs_inc;
                if (ofs_inc >= exp_q) begin
                  status_d[b] = sfr_pkg::ST_CHECK;
                end
              end
              sfr_pkg::ST_CHECK: begin
                xor_d = xor_n;
                wake  = 1'b1;
                if (xor_n != 8'd0) begin
                  status_d[b] = sfr_pkg::ST_ERR_CHECK;
                  err_d       = 1'b1;
                end else begin
                  status_d[b] = sfr_pkg::ST_READY;
                  fill_d      = ~b;
                end
              end
              default: begin
                // ready buffer not yet released, or a code without meaning
                status_d[b] = sfr_pkg::ST_ERR_OVERRUN;
                err_d       = 1'b1;
                wake        = 1'b1;
              end
            endcase
          end
        end
        sfr_pkg::OP_RELEASE: begin
          if (err_q) begin
            status_d = '{sfr_pkg::ST_IDLE, sfr_pkg::ST_IDLE};
            ep_d     = '{8'd0, 8'd0};
            len_d    = '{9'd0, 9'd0};
            exp_d    = '0;
            ofs_d    = '0;
            xor_d    = 8'd0;
            fill_d   = 1'b0;
            drain_d  = 1'b0;
            err_d    = 1'b0;
          end else begin
            status_d[drain_q] = sfr_pkg::ST_IDLE;
            drain_d           = ~drain_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // held byte lookup qualifies against the state after the update
  assign hit = (op == sfr_pkg::OP_READ) && (status_d[drain_d] == sfr_pkg::ST_READY) &&
               ({1'b0, read_index_i} <
                (10'(sfr_pkg::HEADER_BYTES) + {1'b0, len_d[drain_d]})) &&
               ({1'b0, read_index_i} < 10'(sfr_pkg::BUF_BYTES));

  // frame store requests
  always_comb begin
    mem_o.we    = store_en && (ofs_q < OW'(sfr_pkg::BUF_BYTES));
    mem_o.waddr = (b ? AW'(sfr_pkg::BUF_BYTES) : AW'(0)) + AW'(ofs_q);
    mem_o.wdata = v;
    mem_o.re    = accept && hit;
    mem_o.raddr = (drain_d ? AW'(sfr_pkg::BUF_BYTES) : AW'(0)) + AW'(read_index_i);
  end

  // result fields
  always_comb begin
    res_o.rx_status      = status_d[fill_d];
    res_o.held_status    = status_d[drain_d];
    res_o.endpoint       = ep_d[drain_d];
    res_o.payload_length = len_d[drain_d];
    res_o.error_latched  = err_d;
    res_o.wake           = wake;
    res_o.read_hit       = hit;
  end
  assign res_valid_o = accept;

  // configuration writes
  always_comb begin
    start_d = start_q;
    limit_d = limit_q;
    if (cfg_we_i) begin
      case (sfr_pkg::sfr_cfg_e'(cfg_index_i))
        sfr_pkg::CFG_START_BYTE:    start_d = cfg_data_i[7:0];
        sfr_pkg::CFG_PAYLOAD_LIMIT: limit_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '{sfr_pkg::ST_IDLE, sfr_pkg::ST_IDLE};
      ep_q     <= '{8'd0, 8'd0};
      len_q    <= '{9'd0, 9'd0};
      exp_q    <= '0;
      ofs_q    <= '0;
      xor_q    <= 8'd0;
      fill_q   <= 1'b0;
      drain_q  <= 1'b0;
      err_q    <= 1'b0;
      lenlo_q  <= 9'd0;
      lenhi_q  <= 1'b0;
      start_q  <= sfr_pkg::START_BYTE_RST;
      limit_q  <= sfr_pkg::PAYLOAD_LIMIT_RST;
    end else begin
      status_q <= status_d;
      ep_q     <= ep_d;
      len_q    <= len_d;
      exp_q    <= exp_d;
      ofs_q    <= ofs_d;
      xor_q    <= xor_d;
      fill_q   <= fill_d;
      drain_q  <= drain_d;
      err_q    <= err_d;
      lenlo_q  <= lenlo_d;
      lenhi_q  <= lenhi_d;
      start_q  <= start_d;
      limit_q  <= limit_d;
    end
  end

endmodule

/* src/sfr_back.sv */
// back end: joins store read data to the result and queues results for output
module sfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  sfr_pkg::sfr_res_t res_i,
  input  logic [7:0]        rdata_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfr_pkg::sfr_out_t out_o
);

  localparam int PW = sfr_pkg::PTR_W;
  localparam int CW = sfr_pkg::CNT_W;

  logic              s1_valid_q;
  sfr_pkg::sfr_res_t s1_q;
  sfr_pkg::sfr_out_t fifo_q [sfr_pkg::FIFO_DEPTH];
  sfr_pkg::sfr_out_t entry;
  logic [PW-1:0]     wptr_q, rptr_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              push, pop;

  // accept only when queue plus staged item leave a free slot
  assign ready_o = (cnt_q + CW'(s1_valid_q)) < CW'(sfr_pkg::FIFO_DEPTH);

  assign push        = s1_valid_q;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  // merge read data, zero when the lookup missed
  always_comb begin
    entry.rx_status      = s1_q.rx_status;
    entry.held_status    = s1_q.held_status;
    entry.endpoint       = s1_q.endpoint;
    entry.payload_length = s1_q.payload_length;
    entry.read_byte      = s1_q.read_hit ? rdata_i : 8'd0;
    entry.error_latched  = s1_q.error_latched;
    entry.wake           = s1_q.wake;
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CW'(1);
      2'b01:   cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // staging register and queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= res_valid_i;
      cnt_q      <= cnt_d;
      if (push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      s1_q <= res_i;
    end
    if (push) begin
      fifo_q[wptr_q] <= entry;
    end
  end

  assign out_o = fifo_q[rptr_q];

endmodule

/* src/sfr_checker.sv */
// port-level checks of the serial frame receiver and their bind
module sfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] rx_status_o,
  input logic [3:0] held_status_o,
  input logic [7:0] endpoint_o,
  input logic [8:0] payload_length_o,
  input logic [7:0] read_byte_o,
  input logic       error_latched_o,
  input logic       wake_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(rx_status_o) && $stable(held_status_o) &&
      $stable(endpoint_o) && $stable(payload_length_o) && $stable(read_byte_o) &&
      $stable(error_latched_o) && $stable(wake_o))
    else $error("stalled result changed");

  // the error flag is set exactly while the filling buffer shows an error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (error_latched_o == (rx_status_o >= sfr_pkg::ST_ERR_START)))
    else $error("error flag disagrees with filling buffer status");

  // held bytes come only from a ready frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_byte_o != 8'd0) |-> (held_status_o == sfr_pkg::ST_READY))
    else $error("byte read from a frame that is not ready");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

/* tb/serial_frame_receiver_test.sv */
// testbench of the serial frame receiver: framed byte traffic checked against a frame predictor
`timescale 1ns / 100ps

module serial_frame_receiver_test;
  import sfr_pkg::*;

  // one operation offered to the block
  typedef struct packed {
    sfr_op_e    op;
    logic [7:0] rx;
    logic [8:0] idx;
  } frame_op_t;

  // ways a generated frame can be broken
  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_START,
    FLAW_CHECK,
    FLAW_CUT
  } flaw_e;

  logic       clk_i;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [1:0] operation_i      = 2'd0;
  logic [7:0] rx_byte_i        = 8'd0;
  logic [8:0] read_index_i     = 9'd0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [3:0] rx_status_o;
  logic [3:0] held_status_o;
  logic [7:0] endpoint_o;
  logic [8:0] payload_length_o;
  logic [7:0] read_byte_o;
  logic       error_latched_o;
  logic       wake_o;
  logic       cfg_we_i         = 1'b0;
  logic       cfg_index_i      = 1'b0;
  logic [8:0] cfg_data_i       = 9'd0;

  serial_frame_receiver dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .rx_byte_i        (rx_byte_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rx_status_o      (rx_status_o),
    .held_status_o    (held_status_o),
    .endpoint_o       (endpoint_o),
    .payload_length_o (payload_length_o),
    .read_byte_o      (read_byte_o),
    .error_latched_o  (error_latched_o),
    .wake_o           (wake_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // predicted block state
  logic [7:0]   cfg_start;
  logic [8:0]   cfg_limit;
  logic [7:0]   store_m [STORE_DEPTH];
  sfr_status_e  buf_st [2];
  logic [7:0]   buf_ep [2];
  logic [8:0]   buf_len [2];
  int unsigned  want_total;
  int unsigned  ofs;
  logic [7:0]   xor_acc;
  logic         fill_sel;
  logic         drain_sel;
  logic         err_flag;

  // pending operations and predicted status items
  frame_op_t    op_q [$];
  sfr_out_t     status_q [$];
  int unsigned  n_pushed   = 0;
  int unsigned  n_results  = 0;
  int unsigned  mismatches = 0;

  // sender and receiver bookkeeping
  frame_op_t    cur_op     = '0;
  logic         xfer;
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  logic [15:0]  stall_pat  = 16'h0000;
  logic [3:0]   stall_pos  = 4'd0;
  sfr_out_t     got_r;
  sfr_out_t     want_r;

  function automatic void clear_buffers();
    for (int k = 0; k < 2; k++) begin
      buf_st[k]  = ST_IDLE;
      buf_ep[k]  = 8'd0;
      buf_len[k] = 9'd0;
    end
    want_total = 0;
    ofs        = 0;
    xor_acc    = 8'd0;
    fill_sel   = 1'b0;
    drain_sel  = 1'b0;
    err_flag   = 1'b0;
  endfunction

  function automatic logic flag_error(input logic b, input sfr_status_e code);
    buf_st[b] = code;
    err_flag  = 1'b1;
    return 1'b1;
  endfunction

  function automatic void put_byte(input logic b, input logic [7:0] v);
    if (ofs < BUF_BYTES) store_m[int'(b) * BUF_BYTES + ofs] = v;
    ofs++;
  endfunction

  // parser step for one received byte, returns the wake flag
  function automatic logic take_byte(input logic [7:0] v);
    logic        b;
    logic [31:0] len;
    int unsigned lim;
    b   = fill_sel;
    len = 32'd0;
    lim = (cfg_limit < MAX_PAYLOAD) ? cfg_limit : MAX_PAYLOAD;
    if (err_flag) return 1'b0;
    case (buf_st[b])
      ST_IDLE: begin
        if (v != cfg_start) return flag_error(b, ST_ERR_START);
        buf_ep[b]  = 8'd0;
        buf_len[b] = 9'd0;
        ofs        = 0;
        xor_acc    = 8'd0;
        want_total = 0;
        buf_st[b]  = ST_ENDPOINT;
      end
      ST_ENDPOINT: begin
        buf_ep[b]  = v;
        xor_acc    = v;
        want_total = HEADER_BYTES;
        ofs        = 0;
        buf_st[b]  = ST_HEADER;
      end
      ST_HEADER: begin
        xor_acc ^= v;
        put_byte(b, v);
        if (ofs >= HEADER_BYTES) begin
          // little-endian length, bytes past the header read as zero
          for (int k = 0; k < 4; k++)
            if (LENGTH_OFFSET + k < HEADER_BYTES)
              len[8*k +: 8] = store_m[int'(b) * BUF_BYTES + LENGTH_OFFSET + k];
          if (len > lim) return flag_error(b, ST_ERR_LENGTH);
          buf_len[b] = len[8:0];
          if (len != 0) begin
            want_total = HEADER_BYTES + len;
            buf_st[b]  = ST_PAYLOAD;
          end else begin
            buf_st[b] = ST_CHECK;
          end
        end
      end
      ST_PAYLOAD: begin
        xor_acc ^= v;
        put_byte(b, v);
        if (ofs >= want_total) buf_st[b] = ST_CHECK;
      end
      ST_CHECK: begin
        xor_acc ^= v;
        if (xor_acc != 8'd0) return flag_error(b, ST_ERR_CHECK);
        buf_st[b] = ST_READY;
        fill_sel  = ~b;
        return 1'b1;
      end
      default: return flag_error(b, ST_ERR_OVERRUN);
    endcase
    return 1'b0;
  endfunction

  // predicted status item for one transferred operation
  function automatic sfr_out_t deframe_step(input frame_op_t it);
    sfr_out_t r;
    logic     wake;
    wake = 1'b0;
    if (it.op == OP_RECEIVE) begin
      wake = take_byte(it.rx);
    end else if (it.op == OP_RELEASE) begin
      if (err_flag) begin
        clear_buffers();
      end else begin
        buf_st[drain_sel] = ST_IDLE;
        drain_sel         = ~drain_sel;
      end
    end
    r.read_byte = 8'h00;
    if (it.op == OP_READ && buf_st[drain_sel] == ST_READY &&
        int'(it.idx) < HEADER_BYTES + int'(buf_len[drain_sel]) && int'(it.idx) < BUF_BYTES)
      r.read_byte = store_m[int'(drain_sel) * BUF_BYTES + int'(it.idx)];
    r.rx_status      = buf_st[fill_sel];
    r.held_status    = buf_st[drain_sel];
    r.endpoint       = buf_ep[drain_sel];
    r.payload_length = buf_len[drain_sel];
    r.error_latched  = err_flag;
    r.wake           = wake;
    return r;
  endfunction

  task automatic push_op(input sfr_op_e op, input logic [7:0] rx, input logic [8:0] idx);
    frame_op_t it;
    it.op  = op;
    it.rx  = rx;
    it.idx = idx;
    op_q.push_back(it);
    n_pushed++;
  endtask

  // start, endpoint, header with length field, payload, check byte
  task automatic push_frame(input logic [7:0] ep, input logic [31:0] len_field,
                            input int unsigned pay_n, input flaw_e flaw);
    logic [7:0]  hdr [HEADER_BYTES];
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned cut;
    cut = $urandom_range(0, HEADER_BYTES - 1);
    sum = ep;
    if (flaw == FLAW_START)
      push_op(OP_RECEIVE, cfg_start ^ 8'($urandom_range(1, 255)), 9'($urandom));
    else
      push_op(OP_RECEIVE, cfg_start, 9'($urandom));
    push_op(OP_RECEIVE, ep, 9'($urandom));
    for (int k = 0; k < HEADER_BYTES; k++) begin
      hdr[k] = 8'($urandom);
      if (k >= LENGTH_OFFSET && k < LENGTH_OFFSET + 4)
        hdr[k] = len_field[8*(k-LENGTH_OFFSET) +: 8];
    end
    for (int k = 0; k < HEADER_BYTES; k++) begin
      if (flaw == FLAW_CUT && k == cut) return;
      push_op(OP_RECEIVE, hdr[k], 9'($urandom));
      sum ^= hdr[k];
    end
    for (int k = 0; k < pay_n; k++) begin
      b = 8'($urandom);
      push_op(OP_RECEIVE, b, 9'($urandom));
      sum ^= b;
    end
    if (flaw == FLAW_CHECK) sum ^= 8'd1 << $urandom_range(0, 7);
    push_op(OP_RECEIVE, sum, 9'($urandom));
  endtask

  // consumer: query, up to four reads of the held frame, release
  task automatic drain_held(input int unsigned span);
    push_op(OP_QUERY, 8'($urandom), 9'($urandom));
    repeat ($urandom_range(0, 4))
      push_op(OP_READ, 8'($urandom), ($urandom_range(0, 7) == 0) ?
              9'($urandom) : 9'($urandom_range(0, HEADER_BYTES + span)));
    push_op(OP_RELEASE, 8'($urandom), 9'($urandom));
  endtask

  // mostly well-formed frames and drains, some broken frames and noise
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned lim;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  ep;
    stop_at = n_pushed + count;
    while (n_pushed < stop_at) begin
      lim  = (cfg_limit < MAX_PAYLOAD) ? cfg_limit : MAX_PAYLOAD;
      len  = ($urandom_range(0, 99) == 0) ? lim : $urandom_range(0, (lim < 16) ? lim : 16);
      ep   = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_frame(ep, len, len, FLAW_NONE);
        if ($urandom_range(0, 3) != 0) drain_held(len);
      end else if (pick < 62) begin
        push_frame(ep, len, len, FLAW_CHECK);
        push_op(OP_RELEASE, 8'($urandom), 9'($urandom));
      end else if (pick < 67) begin
        push_frame(ep, len, len, FLAW_START);
        push_op(OP_RELEASE, 8'($urandom), 9'($urandom));
      end else if (pick < 73) begin
        // oversize length, either just past the limit or with high bits set
        push_frame(ep, ($urandom_range(0, 1) == 1) ? ($urandom | 32'h200) :
                   lim + 1 + $urandom_range(0, 3), 3, FLAW_NONE);
        push_op(OP_RELEASE, 8'($urandom), 9'($urandom));
      end else if (pick < 78) begin
        push_frame(ep, len, len, FLAW_CUT);
        push_op(OP_RELEASE, 8'($urandom), 9'($urandom));
      end else if (pick < 88) begin
        drain_held(len);
      end else begin
        repeat ($urandom_range(1, 6))
          push_op(sfr_op_e'($urandom_range(0, 3)), 8'($urandom), 9'($urandom));
      end
    end
  endtask

  // hold the sender until every predicted item has come back
  task automatic wait_idle();
    while (op_q.size() != 0 || in_valid_i || status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input sfr_cfg_e idx, input logic [8:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_START_BYTE) cfg_start = v[7:0];
    else cfg_limit = v;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: bursts of transfers with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      xfer = in_valid_i && !in_stall_o;
      if (xfer) begin
        status_q.push_back(deframe_step(cur_op));
        void'(op_q.pop_front());
      end
      if (!in_valid_i || xfer) begin
        if (gap_left != 0 || op_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          cur_op       = op_q[0];
          operation_i  <= cur_op.op;
          rx_byte_i    <= cur_op.rx;
          read_index_i <= cur_op.idx;
          in_valid_i   <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern, reloaded whenever the stall position reaches 15
  always @(posedge clk_i) begin
    if (stall_pos == 4'd15) begin
      case ($urandom_range(0, 7))
        0, 1:    stall_pat <= 16'h0000;
        2:       stall_pat <= 16'hffff;
        3, 4:    stall_pat <= 16'($urandom & $urandom);
        default: stall_pat <= 16'($urandom);
      endcase
    end
    out_stall_i <= stall_pat[stall_pos];
    stall_pos   <= stall_pos + 4'd1;
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_r.rx_status      = sfr_status_e'(rx_status_o);
      got_r.held_status    = sfr_status_e'(held_status_o);
      got_r.endpoint       = endpoint_o;
      got_r.payload_length = payload_length_o;
      got_r.read_byte      = read_byte_o;
      got_r.error_latched  = error_latched_o;
      got_r.wake           = wake_o;
      n_results++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result %0d arrived with nothing predicted", $time, n_results);
      end else begin
        want_r = status_q.pop_front();
        if (got_r.rx_status !== want_r.rx_status ||
            got_r.held_status !== want_r.held_status ||
            got_r.endpoint !== want_r.endpoint ||
            got_r.payload_length !== want_r.payload_length ||
            got_r.read_byte !== want_r.read_byte ||
            got_r.error_latched !== want_r.error_latched ||
            got_r.wake !== want_r.wake) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d expected rx %0d held %0d ep %h len %0d byte %h err %b wake %b",
                     $time, n_results, want_r.rx_status, want_r.held_status, want_r.endpoint,
                     want_r.payload_length, want_r.read_byte, want_r.error_latched, want_r.wake);
            $display("%0t: result %0d actual   rx %0d held %0d ep %h len %0d byte %h err %b wake %b",
                     $time, n_results, got_r.rx_status, got_r.held_status, got_r.endpoint,
                     got_r.payload_length, got_r.read_byte, got_r.error_latched, got_r.wake);
          end
        end
      end
    end
  end

  // stimulus phases
  initial begin
    for (int k = 0; k < STORE_DEPTH; k++) store_m[k] = 8'd0;
    clear_buffers();
    cfg_start = START_BYTE_RST;
    cfg_limit = PAYLOAD_LIMIT_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty frame with endpoint at its top value, reads inside and past it
    push_frame(8'hff, 32'd0, 0, FLAW_NONE);
    push_op(OP_QUERY, 8'h00, 9'd0);
    push_op(OP_READ, 8'hff, 9'd0);
    push_op(OP_READ, 8'h00, 9'd9);
    push_op(OP_READ, 8'h00, 9'd10);
    push_op(OP_READ, 8'h00, 9'h1ff);
    push_op(OP_RELEASE, 8'h00, 9'd0);
    // bad start byte, byte ignored while latched, release clearing the error
    push_op(OP_RECEIVE, 8'h00, 9'd0);
    push_op(OP_RECEIVE, START_BYTE_RST, 9'h1ff);
    push_op(OP_RELEASE, 8'h00, 9'd0);
    // read with nothing held, releases of idle buffers
    push_op(OP_READ, 8'h00, 9'd0);
    push_op(OP_RELEASE, 8'h00, 9'd0);
    push_op(OP_RELEASE, 8'h00, 9'd0);
    wait_idle();

    // zero start byte, full payload limit, one frame at the largest size
    write_reg(CFG_START_BYTE, 9'h000);
    write_reg(CFG_PAYLOAD_LIMIT, 9'(MAX_PAYLOAD));
    push_frame(8'h5a, MAX_PAYLOAD, MAX_PAYLOAD, FLAW_NONE);
    push_op(OP_QUERY, 8'h00, 9'd0);
    push_op(OP_READ, 8'h00, 9'(BUF_BYTES - 1));
    push_op(OP_READ, 8'h00, 9'(BUF_BYTES));
    push_op(OP_RELEASE, 8'h00, 9'd0);
    run_random(200);
    wait_idle();

    // top start byte, zero payload limit
    write_reg(CFG_START_BYTE, 9'h0ff);
    write_reg(CFG_PAYLOAD_LIMIT, 9'd0);
    run_random(120);
    wait_idle();

    // random start byte, small limit
    write_reg(CFG_START_BYTE, 9'($urandom_range(0, 255)));
    write_reg(CFG_PAYLOAD_LIMIT, 9'($urandom_range(1, 40)));
    run_random(250);
    wait_idle();

    // back to the reset settings
    write_reg(CFG_START_BYTE, 9'(START_BYTE_RST));
    write_reg(CFG_PAYLOAD_LIMIT, PAYLOAD_LIMIT_RST);
    run_random(130);
    wait_idle();

    mismatches += status_q.size();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
